FILE: hw/rtl/ecu_pkg.sv
`timescale 1ns / 1ps

package ecu_pkg;

  localparam int EPOCH_W = 32;
  localparam int YEAR_W  = 8;
  localparam int YDAY_W  = 9;
  localparam int MON_W   = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam int DAYS_W  = 16;
  localparam int SOD_W   = 17;
  localparam int CNT_W   = 3;

  localparam logic [SOD_W:0]     SECS_PER_DAY = 18'd86400;
  localparam logic [SOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
  localparam logic [SOD_W-1:0]   SECS_PER_MIN = 17'd60;

  // floor division by a constant: drop the power of two, then multiply by
  // the rounded-up reciprocal of the odd part and keep the high bits
  // seconds / 86400 = (seconds >> 7) / 675
  localparam int                 DAY_SHIFT    = 7;
  localparam int                 DAY_RECIP_SH = 35;
  localparam int                 DAY_PROD_W   = 51;
  localparam logic [25:0]        DAY_RECIP    = 26'd50903317;
  // second of day / 3600 = (second of day >> 4) / 225
  localparam int                 HOUR_SHIFT    = 4;
  localparam int                 HOUR_RECIP_SH = 21;
  localparam int                 HOUR_PROD_W   = 27;
  localparam logic [13:0]        HOUR_RECIP    = 14'd9321;
  // second of hour / 60 = (second of hour >> 2) / 15
  localparam int                 MIN_SHIFT    = 2;
  localparam int                 MIN_RECIP_SH = 14;
  localparam int                 MIN_PROD_W   = 21;
  localparam logic [10:0]        MIN_RECIP    = 11'd1093;

  localparam int DIV_STEPS       = 2;
  localparam int HMS_STEPS       = 4;

  localparam logic [CNT_W-1:0]   DIV_DAY_Q  = 3'd0;
  localparam logic [CNT_W-1:0]   DIV_DAY_R  = 3'd1;
  localparam logic [CNT_W-1:0]   HMS_HOUR_Q = 3'd0;
  localparam logic [CNT_W-1:0]   HMS_HOUR_R = 3'd1;
  localparam logic [CNT_W-1:0]   HMS_MIN_Q  = 3'd2;
  localparam logic [CNT_W-1:0]   HMS_MIN_R  = 3'd3;

  localparam logic [YEAR_W-1:0]  BASE_YEAR_1900 = 8'd70;
  localparam logic [1:0]         BASE_MOD4      = 2'd2;
  localparam logic [6:0]         BASE_MOD100    = 7'd70;
  localparam logic [8:0]         BASE_MOD400    = 9'd370;
  localparam logic [6:0]         LAST_MOD100    = 7'd99;
  localparam logic [8:0]         LAST_MOD400    = 9'd399;

  localparam logic [YDAY_W-1:0]  DAYS_COMMON = 9'd365;
  localparam logic [YDAY_W-1:0]  DAYS_LEAP   = 9'd366;

  localparam logic [MON_W-1:0]   MON_JAN = 4'd0;
  localparam logic [MON_W-1:0]   MON_FEB = 4'd1;
  localparam logic [MON_W-1:0]   MON_APR = 4'd3;
  localparam logic [MON_W-1:0]   MON_JUN = 4'd5;
  localparam logic [MON_W-1:0]   MON_SEP = 4'd8;
  localparam logic [MON_W-1:0]   MON_NOV = 4'd10;
  localparam logic [MON_W-1:0]   MON_DEC = 4'd11;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             hms_step;
    logic [CNT_W-1:0] step_idx;
    logic             year_step;
    logic             mon_load;
    logic             mon_step;
    logic             out_load;
  } ecu_cmd_t;

  typedef struct packed {
    logic year_done;
    logic mon_done;
  } ecu_sts_t;

  function automatic logic [MDAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                   input logic leap);
    logic [MDAY_W-1:0] n;
    case (mon)
      MON_FEB: n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/epoch_to_calendar_utc.sv
`timescale 1ns / 1ps

// Unix seconds to broken-down UTC calendar time, Gregorian leap rule.
// Input channel: in_valid/in_ready with in_epoch_seconds, unsigned seconds
// since 1970-01-01 00:00:00. Output channel: out_valid/out_ready with year
// since 1900, day of year, month 0..11, day of month, hour, minute, second.
// One word in, one word out, one word in flight at a time. Reciprocal
// multiplies split the day count from the second of day (quotient step,
// then remainder step); then the year walk (one year per cycle, 0 to 136
// years) runs alongside the split of the second of day into hour, minute
// and second (hour quotient, hour remainder, minute quotient, minute
// remainder), and the month walk follows, stopping at December. in_ready
// is high only when idle, so a new word is taken only after the last
// result has been loaded into the output register; the next word can be
// accepted while a finished result sits in the output register. If the
// receiver stalls, the result holds, and the following conversion
// completes but waits before overwriting it.
// Synchronous active-low reset returns to idle with no output pending;
// no memory needs clearing.

module epoch_to_calendar_utc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ecu_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ecu_pkg::YEAR_W-1:0]   out_year_since_1900,
  output logic [ecu_pkg::YDAY_W-1:0]   out_day_of_year,
  output logic [ecu_pkg::MON_W-1:0]    out_month_index,
  output logic [ecu_pkg::MDAY_W-1:0]   out_day_of_month,
  output logic [ecu_pkg::HOUR_W-1:0]   out_hour_of_day,
  output logic [ecu_pkg::MIN_W-1:0]    out_minute_of_hour,
  output logic [ecu_pkg::SEC_W-1:0]    out_second_of_minute
);
  import ecu_pkg::*;

  ecu_cmd_t cmd;
  ecu_sts_t sts;

  ecu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ecu_dp u_dp (
    .clk                  (clk),
    .in_epoch_seconds     (in_epoch_seconds),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_year_since_1900  (out_year_since_1900),
    .out_day_of_year      (out_day_of_year),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accepting a word");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index <= MON_DEC) && (out_day_of_month != '0))
    else $error("month or day of month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_of_day < 5'd24) && (out_minute_of_hour < 6'd60)
                  && (out_second_of_minute < 6'd60))
    else $error("time of day out of range");
`endif

endmodule

FILE: hw/rtl/ecu_ctrl.sv
`timescale 1ns / 1ps

module ecu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ecu_pkg::ecu_sts_t sts,
  output ecu_pkg::ecu_cmd_t cmd
);
  import ecu_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_MON  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             hms_busy;

  assign hms_busy = (cnt_r != CNT_W'(HMS_STEPS));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.step_idx = cnt_r;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // time of day and year walk run side by side
        cmd.hms_step  = hms_busy;
        cmd.step_idx  = cnt_r;
        cmd.year_step = !sts.year_done;
        if (hms_busy) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!hms_busy && sts.year_done) begin
          cmd.mon_load = 1'b1;
          state_nxt    = ST_MON;
        end
      end
      ST_MON: begin
        if (sts.mon_done) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/ecu_dp.sv
`timescale 1ns / 1ps

module ecu_dp (
  input  logic                         clk,
  input  logic [ecu_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  input  ecu_pkg::ecu_cmd_t            cmd,
  output ecu_pkg::ecu_sts_t            sts,
  output logic [ecu_pkg::YEAR_W-1:0]   out_year_since_1900,
  output logic [ecu_pkg::YDAY_W-1:0]   out_day_of_year,
  output logic [ecu_pkg::MON_W-1:0]    out_month_index,
  output logic [ecu_pkg::MDAY_W-1:0]   out_day_of_month,
  output logic [ecu_pkg::HOUR_W-1:0]   out_hour_of_day,
  output logic [ecu_pkg::MIN_W-1:0]    out_minute_of_hour,
  output logic [ecu_pkg::SEC_W-1:0]    out_second_of_minute
);
  import ecu_pkg::*;

  logic [EPOCH_W-1:0] num_r;
  logic [SOD_W-1:0]   rem_r;
  logic [DAYS_W-1:0]  days_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   min_r;
  logic [YEAR_W-1:0]  year_r;
  logic [1:0]         mod4_r;
  logic [6:0]         mod100_r;
  logic [8:0]         mod400_r;
  logic [MON_W-1:0]   mon_r;
  logic [YDAY_W-1:0]  dom_r;

  logic [YEAR_W-1:0]  year_q_r;
  logic [YDAY_W-1:0]  yday_q_r;
  logic [MON_W-1:0]   mon_q_r;
  logic [MDAY_W-1:0]  mday_q_r;
  logic [HOUR_W-1:0]  hour_q_r;
  logic [MIN_W-1:0]   min_q_r;
  logic [SEC_W-1:0]   sec_q_r;

  logic [DAY_PROD_W-1:0]  day_prod;
  logic [EPOCH_W-1:0]     day_base;
  logic [HOUR_PROD_W-1:0] hour_prod;
  logic [SOD_W-1:0]       hour_base;
  logic [MIN_PROD_W-1:0]  min_prod;
  logic [SOD_W-1:0]       min_base;

  logic               leap;
  logic [YDAY_W-1:0]  ylen;
  logic [MDAY_W-1:0]  mlen;

  assign day_prod  = DAY_PROD_W'(num_r[EPOCH_W-1:DAY_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
  assign day_base  = EPOCH_W'(days_r) * EPOCH_W'(SECS_PER_DAY);
  assign hour_prod = HOUR_PROD_W'(rem_r[SOD_W-1:HOUR_SHIFT]) * HOUR_PROD_W'(HOUR_RECIP);
  assign hour_base = SOD_W'(hour_r) * SECS_PER_HOUR;
  assign min_prod  = MIN_PROD_W'(rem_r[SOD_W-1:MIN_SHIFT]) * MIN_PROD_W'(MIN_RECIP);
  assign min_base  = SOD_W'(min_r) * SECS_PER_MIN;

  assign leap = (mod4_r == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen = month_days(mon_r, leap);

  assign sts.year_done = (days_r < DAYS_W'(ylen));
  assign sts.mon_done  = (mon_r == MON_DEC) || (dom_r < YDAY_W'(mlen));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r    <= in_epoch_seconds;
      year_r   <= BASE_YEAR_1900;
      mod4_r   <= BASE_MOD4;
      mod100_r <= BASE_MOD100;
      mod400_r <= BASE_MOD400;
    end
    if (cmd.div_step) begin
      case (cmd.step_idx)
        DIV_DAY_Q: days_r <= day_prod[DAY_RECIP_SH +: DAYS_W];
        DIV_DAY_R: rem_r  <= SOD_W'(num_r - day_base);
        default: ;
      endcase
    end
    if (cmd.hms_step) begin
      case (cmd.step_idx)
        HMS_HOUR_Q: hour_r <= hour_prod[HOUR_RECIP_SH +: HOUR_W];
        HMS_HOUR_R: rem_r  <= rem_r - hour_base;
        HMS_MIN_Q:  min_r  <= min_prod[MIN_RECIP_SH +: MIN_W];
        HMS_MIN_R:  rem_r  <= rem_r - min_base;
        default: ;
      endcase
    end
    if (cmd.year_step) begin
      days_r   <= days_r - DAYS_W'(ylen);
      year_r   <= year_r + 1'b1;
      mod4_r   <= mod4_r + 1'b1;
      mod100_r <= (mod100_r == LAST_MOD100) ? 7'd0 : mod100_r + 1'b1;
      mod400_r <= (mod400_r == LAST_MOD400) ? 9'd0 : mod400_r + 1'b1;
    end
    if (cmd.mon_load) begin
      mon_r <= MON_JAN;
      dom_r <= days_r[YDAY_W-1:0];
    end
    if (cmd.mon_step) begin
      mon_r <= mon_r + 1'b1;
      dom_r <= dom_r - YDAY_W'(mlen);
    end
    if (cmd.out_load) begin
      year_q_r <= year_r;
      yday_q_r <= days_r[YDAY_W-1:0];
      mon_q_r  <= mon_r;
      mday_q_r <= dom_r[MDAY_W-1:0] + 1'b1;
      hour_q_r <= hour_r;
      min_q_r  <= min_r;
      sec_q_r  <= rem_r[SEC_W-1:0];
    end
  end

  assign out_year_since_1900  = year_q_r;
  assign out_day_of_year      = yday_q_r;
  assign out_month_index      = mon_q_r;
  assign out_day_of_month     = mday_q_r;
  assign out_hour_of_day      = hour_q_r;
  assign out_minute_of_hour   = min_q_r;
  assign out_second_of_minute = sec_q_r;

endmodule

FILE: dv/tb_epoch_to_calendar_utc.sv
`timescale 1ns / 1ps

module tb_epoch_to_calendar_utc;

  typedef struct {
    logic [ecu_pkg::EPOCH_W-1:0] epoch;
    logic [ecu_pkg::YEAR_W-1:0]  year;
    logic [ecu_pkg::YDAY_W-1:0]  yday;
    logic [ecu_pkg::MON_W-1:0]   mon;
    logic [ecu_pkg::MDAY_W-1:0]  mday;
    logic [ecu_pkg::HOUR_W-1:0]  hour;
    logic [ecu_pkg::MIN_W-1:0]   minute;
    logic [ecu_pkg::SEC_W-1:0]   second;
  } cal_t;

  typedef struct {
    logic [ecu_pkg::EPOCH_W-1:0] epoch;
    bit                          drain_first;
  } epoch_req_t;

  localparam int N_EDGE = 25;
  localparam int N_RANDOM = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ecu_pkg::EPOCH_W-1:0] in_epoch_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ecu_pkg::YEAR_W-1:0] out_year_since_1900;
  logic [ecu_pkg::YDAY_W-1:0] out_day_of_year;
  logic [ecu_pkg::MON_W-1:0] out_month_index;
  logic [ecu_pkg::MDAY_W-1:0] out_day_of_month;
  logic [ecu_pkg::HOUR_W-1:0] out_hour_of_day;
  logic [ecu_pkg::MIN_W-1:0] out_minute_of_hour;
  logic [ecu_pkg::SEC_W-1:0] out_second_of_minute;

  epoch_req_t epoch_backlog[$];
  cal_t due_dates[$];
  epoch_req_t next_req;
  cal_t want;

  int accepted = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int n_words = 0;
  int n_leap_days = 0;
  int n_late = 0;
  logic quiet;

  // no idling on either side for a stretch of every 200 words
  assign quiet = (accepted % 200) < 40;

  epoch_to_calendar_utc DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_epoch_seconds    (in_epoch_seconds),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_year_since_1900 (out_year_since_1900),
    .out_day_of_year     (out_day_of_year),
    .out_month_index     (out_month_index),
    .out_day_of_month    (out_day_of_month),
    .out_hour_of_day     (out_hour_of_day),
    .out_minute_of_hour  (out_minute_of_hour),
    .out_second_of_minute(out_second_of_minute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic cal_t to_calendar(input logic [ecu_pkg::EPOCH_W-1:0] secs);
    cal_t c;
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned ylen;
    int unsigned mlen;
    logic [ecu_pkg::MON_W-1:0] mon;
    int unsigned mlens[12];
    mlens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    days = secs / 86400;
    sod = secs % 86400;
    yr = 1970;
    ylen = gregorian_leap(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = gregorian_leap(yr) ? 366 : 365;
    end
    c.epoch = secs;
    c.year = ecu_pkg::YEAR_W'(yr - 1900);
    c.yday = ecu_pkg::YDAY_W'(days);
    mon = ecu_pkg::MON_JAN;
    while (mon < ecu_pkg::MON_DEC) begin
      mlen = mlens[mon];
      if (mon == ecu_pkg::MON_FEB && gregorian_leap(yr)) begin
        mlen = 29;
      end
      if (days < mlen) begin
        break;
      end
      days -= mlen;
      mon++;
    end
    c.mon = mon;
    c.mday = ecu_pkg::MDAY_W'(days + 1);
    c.hour = ecu_pkg::HOUR_W'(sod / 3600);
    c.minute = ecu_pkg::MIN_W'((sod % 3600) / 60);
    c.second = ecu_pkg::SEC_W'(sod % 60);
    return c;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ecu_pkg::EPOCH_W-1:0] random_epoch();
    int unsigned kind;
    longint unsigned t;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      return $urandom();
    end else if (kind <= 6) begin
      // midnight, just after, and just before the next midnight
      t = longint'($urandom_range(0, 49710)) * 86400;
      case ($urandom_range(0, 2))
        0: t = t;
        1: t = t + 1;
        default: t = t + 86399;
      endcase
      if (t > 64'hFFFF_FFFF) begin
        t = $urandom();
      end
      return t[31:0];
    end else if (kind == 7) begin
      return $urandom_range(0, 63072000);
    end
    return $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v,
                                 input logic [ecu_pkg::EPOCH_W-1:0] secs);
    if (mismatch_count < 40) begin
      $display("%0t: %s wrong for epoch %0d: got %0d, want %0d", $time, what, secs, got,
               exp_v);
    end
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        due_dates.push_back(to_calendar(in_epoch_seconds));
        accepted++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (epoch_backlog.size() > 0 &&
                     !(epoch_backlog[0].drain_first && due_dates.size() > 0)) begin
          next_req = epoch_backlog.pop_front();
          in_valid <= 1'b1;
          in_epoch_seconds <= next_req.epoch;
          gap_left = quiet ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_dates.size() == 0) begin
          report_mismatch("unexpected word", out_year_since_1900, 0, 'x);
        end else begin
          want = due_dates.pop_front();
          n_words++;
          if (want.mon == ecu_pkg::MON_FEB && want.mday == 29) begin
            n_leap_days++;
          end
          if (want.year >= 200) begin
            n_late++;
          end
          if (out_year_since_1900 !== want.year)
            report_mismatch("year_since_1900", out_year_since_1900, want.year, want.epoch);
          if (out_day_of_year !== want.yday)
            report_mismatch("day_of_year", out_day_of_year, want.yday, want.epoch);
          if (out_month_index !== want.mon)
            report_mismatch("month_index", out_month_index, want.mon, want.epoch);
          if (out_day_of_month !== want.mday)
            report_mismatch("day_of_month", out_day_of_month, want.mday, want.epoch);
          if (out_hour_of_day !== want.hour)
            report_mismatch("hour_of_day", out_hour_of_day, want.hour, want.epoch);
          if (out_minute_of_hour !== want.minute)
            report_mismatch("minute_of_hour", out_minute_of_hour, want.minute, want.epoch);
          if (out_second_of_minute !== want.second)
            report_mismatch("second_of_minute", out_second_of_minute, want.second,
                            want.epoch);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = quiet ? 0 : idle_len();
        out_ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    logic [ecu_pkg::EPOCH_W-1:0] edge_epochs [N_EDGE];
    epoch_req_t req;
    // leap day 2000, century 2100, june/july and july/august boundaries, range ends
    edge_epochs = '{32'd0, 32'd1, 32'd59, 32'd3599, 32'd86399, 32'd86400, 32'd31535999,
                    32'd31536000, 32'd946684799, 32'd951782399, 32'd951782400,
                    32'd951868800, 32'd978220800, 32'd1688083200, 32'd1688169600,
                    32'd1690761600, 32'd1690848000, 32'd1735603200, 32'd4102444799,
                    32'd4102444800, 32'd4107456000, 32'd4107542400, 32'd2147483647,
                    32'd2147483648, 32'd4294967295};
    foreach (edge_epochs[k]) begin
      req.epoch = edge_epochs[k];
      req.drain_first = 1'b0;
      epoch_backlog.push_back(req);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      req.epoch = random_epoch();
      req.drain_first = (i % 150 == 0);
      epoch_backlog.push_back(req);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (epoch_backlog.size() > 0 || in_valid || due_dates.size() > 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
    $display("converted %0d epoch words (%0d edge values, rest random)", n_words, N_EDGE);
    $display("%0d landed on Feb 29 and %0d in the year 2100 or later", n_leap_days, n_late);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d words still due", due_dates.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
